>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and held off during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/alfs_pkg.sv
// ---------------------------------------------------------------------------
// alfs_pkg
// Types and constants shared by the addressable LED frame sender.
// ---------------------------------------------------------------------------
package alfs_pkg;

    localparam int COLOR_W  = 24;
    localparam int CB_W     = 5;   // bits to index one colour bit
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    // A frame position never passes the 9-bit pixel count register.
    localparam int POS_W    = 9;

    typedef enum logic [1:0] {
        KIND_SET   = 2'd0,
        KIND_SHOW  = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_TICK  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HIGH = 2'd1,
        PH_LOW  = 2'd2,
        PH_GAP  = 2'd3
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ZERO_HIGH  = 3'd0,
        CFG_ZERO_LOW   = 3'd1,
        CFG_ONE_HIGH   = 3'd2,
        CFG_ONE_LOW    = 3'd3,
        CFG_RESET_GAP  = 3'd4,
        CFG_PIXEL_CNT  = 3'd5,
        CFG_SPARE_6    = 3'd6,
        CFG_SPARE_7    = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0]  zero_high;
        logic [7:0]  zero_low;
        logic [7:0]  one_high;
        logic [7:0]  one_low;
        logic [15:0] reset_gap;
        logic [8:0]  pixel_count;
    } cfg_t;

    localparam logic [7:0]  RST_ZERO_HIGH = 8'd1;
    localparam logic [7:0]  RST_ZERO_LOW  = 8'd2;
    localparam logic [7:0]  RST_ONE_HIGH  = 8'd2;
    localparam logic [7:0]  RST_ONE_LOW   = 8'd1;
    localparam logic [15:0] RST_RESET_GAP = 16'd114;
    localparam logic [8:0]  RST_PIXEL_CNT = 9'd256;

    // Requests from the sequencer to the pixel store
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic clear;
    } st_req_t;

    // Sequencer status, watched by the top level
    typedef struct packed {
        logic   active;
        phase_t phase;
        logic   pend;
    } wave_st_t;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic rejected;
    } res_t;

    // A segment length of zero counts as one tick.
    function automatic logic [15:0] at_least_one(input logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

endpackage

>>> rtl/addressable_led_frame_sender.sv
// ---------------------------------------------------------------------------
// addressable_led_frame_sender
// One-wire addressable LED driver: pixel store, waveform sequencer,
// configuration registers and a registered result stage.
// ---------------------------------------------------------------------------
//  Channel   Signals                              Carries
//  s_*       s_tvalid s_tready s_tdata s_tuser    commands and ticks
//  m_*       m_tvalid m_tready m_tdata            one result per input transfer
//  cfg_*     cfg_valid cfg_ready cfg_index/data   timing and length registers
//
// One item is accepted per cycle; its result is ready in the next cycle.
// A pixel word is read from the store RAM in the cycle a pixel starts and is
// used from the following cycle, so the sequencer never holds the input.
// The input stalls only while a result waits and m_tready is low.
// Reset empties the store at once through per-entry valid bits; no pass.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module addressable_led_frame_sender
    import alfs_pkg::*;
#(
    parameter int MAX_PIXELS     = 256,
    parameter int BITS_PER_PIXEL = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,   // [7:0] pixel_index, [31:8] color
    input  logic [1:0]            s_tuser,   // [1:0] kind
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [0] line_level, [1] busy_res,
                                             // [2] rejected, [7:3] zero
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t               cfg_reg, cfg_next;
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_data_reg;
    logic               fire;
    kind_t              in_kind;
    st_req_t            st_req;
    logic [POS_W-1:0]   raddr;
    logic [COLOR_W-1:0] rd_word;
    res_t               res;
    wave_st_t           wave_st;

    assign in_kind   = kind_t'(s_tuser);
    assign s_tready  = !out_valid_reg || m_tready;
    assign fire      = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    alfs_wave #(
        .MAX_PIXELS     (MAX_PIXELS),
        .BITS_PER_PIXEL (BITS_PER_PIXEL)
    ) u_wave (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .fire        (fire),
        .kind        (in_kind),
        .pixel_index (s_tdata[7:0]),
        .rd_word     (rd_word),
        .st_req      (st_req),
        .raddr       (raddr),
        .res         (res),
        .status      (wave_st)
    );

    alfs_store #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (st_req),
        .waddr   (s_tdata[7:0]),
        .wdata   (s_tdata[31:8]),
        .raddr   (raddr),
        .rd_word (rd_word)
    );

    // Configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ZERO_HIGH: cfg_next.zero_high   = cfg_data[7:0];
                CFG_ZERO_LOW:  cfg_next.zero_low    = cfg_data[7:0];
                CFG_ONE_HIGH:  cfg_next.one_high    = cfg_data[7:0];
                CFG_ONE_LOW:   cfg_next.one_low     = cfg_data[7:0];
                CFG_RESET_GAP: cfg_next.reset_gap   = cfg_data;
                CFG_PIXEL_CNT: cfg_next.pixel_count = cfg_data[8:0];
                CFG_SPARE_6,
                CFG_SPARE_7:   cfg_next = cfg_reg;
            endcase
        end
    end

    // Result stage: loads on every accepted item, empties on a transfer out.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.zero_high   <= RST_ZERO_HIGH;
            cfg_reg.zero_low    <= RST_ZERO_LOW;
            cfg_reg.one_high    <= RST_ONE_HIGH;
            cfg_reg.one_low     <= RST_ONE_LOW;
            cfg_reg.reset_gap   <= RST_RESET_GAP;
            cfg_reg.pixel_count <= RST_PIXEL_CNT;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_data_reg <= {5'b00000, res.rejected, res.busy_res, res.line_level};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `ASSERT_IMPLY(a_pend_in_high, clk, rst_n, wave_st.pend, wave_st.active && (wave_st.phase == PH_HIGH), "pixel read outstanding outside a high segment")
    `ASSERT_ALWAYS(a_active_phase, clk, rst_n, wave_st.active == (wave_st.phase != PH_IDLE), "frame flag and waveform phase disagree")
    `ASSERT_NEXT(a_busy_reject, clk, rst_n, fire && (in_kind != KIND_TICK) && wave_st.active, m_tdata[2], "command during a frame was not rejected")

endmodule

>>> rtl/alfs_ram.sv
// ---------------------------------------------------------------------------
// alfs_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ---------------------------------------------------------------------------
module alfs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/alfs_store.sv
// ---------------------------------------------------------------------------
// alfs_store
// Pixel colour store: RAM plus per-entry valid bits so that reset and a
// clear item empty the whole store at once.
// ---------------------------------------------------------------------------
module alfs_store
    import alfs_pkg::*;
#(
    parameter int MAX_PIXELS = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  st_req_t             req,
    input  logic [7:0]          waddr,
    input  logic [COLOR_W-1:0]  wdata,
    input  logic [POS_W-1:0]    raddr,
    output logic [COLOR_W-1:0]  rd_word
);

    // Only indexes below 256 can ever be written.
    localparam int STORE_DEPTH = (MAX_PIXELS < 256) ? MAX_PIXELS : 256;
    localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    logic [STORE_DEPTH-1:0] valid_reg;
    logic [STORE_DEPTH-1:0] valid_next;
    logic                   rd_ok_reg;
    logic                   rd_ok_next;
    logic                   in_range;
    logic [COLOR_W-1:0]     ram_rdata;

    alfs_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (STORE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (req.wr_en),
        .waddr (waddr[AW-1:0]),
        .wdata (wdata),
        .re    (req.rd_en),
        .raddr (raddr[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign in_range = (32'(raddr) < 32'(STORE_DEPTH));

    always_comb
    begin
        valid_next = valid_reg;
        if (req.clear)
        begin
            valid_next = '0;
        end
        else if (req.wr_en)
        begin
            valid_next[waddr[AW-1:0]] = 1'b1;
        end
        // A read issued together with a clear sees an empty store.
        rd_ok_next = rd_ok_reg;
        if (req.rd_en)
        begin
            rd_ok_next = in_range && !req.clear && valid_reg[raddr[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            rd_ok_reg <= rd_ok_next;
        end
    end

    assign rd_word = rd_ok_reg ? ram_rdata : '0;

endmodule

>>> rtl/alfs_wave.sv
// ---------------------------------------------------------------------------
// alfs_wave
// Waveform sequencer: walks pixels and bits, times the high, low and gap
// segments and issues reads and writes to the pixel store.
// ---------------------------------------------------------------------------
module alfs_wave
    import alfs_pkg::*;
#(
    parameter int MAX_PIXELS     = 256,
    parameter int BITS_PER_PIXEL = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               fire,
    input  kind_t              kind,
    input  logic [7:0]         pixel_index,
    input  logic [COLOR_W-1:0] rd_word,
    output st_req_t            st_req,
    output logic [POS_W-1:0]   raddr,
    output res_t               res,
    output wave_st_t           status
);

    localparam int FRAME_MAX = (MAX_PIXELS < 511) ? MAX_PIXELS : 511;
    localparam int BP_W      = $clog2(BITS_PER_PIXEL);
    localparam int SH_W      = BP_W + 1;

    logic               active_reg,  active_next;
    phase_t             phase_reg,   phase_next;
    logic [POS_W-1:0]   pos_reg,     pos_next;
    logic [BP_W-1:0]    bitpos_reg,  bitpos_next;
    logic [15:0]        count_reg,   count_next;
    logic [COLOR_W-1:0] word_reg,    word_next;
    logic               pend_reg,    pend_next;
    logic [7:0]         plen0_reg,   plen0_next;
    logic [7:0]         plen1_reg,   plen1_next;

    logic [POS_W-1:0]   pif;
    logic [COLOR_W-1:0] cur_word;
    logic [SH_W-1:0]    sh;
    logic [SH_W-1:0]    sh_n;
    logic               cur_bit;
    logic               nxt_bit;
    logic [15:0]        cur_count;
    logic               start_pixel;
    logic [POS_W-1:0]   start_pos;
    logic               rd_go;
    logic               set_ok;
    logic               clear_hit;
    logic               rej;

    // Pixels sent per frame, read live from the register.
    always_comb
    begin
        if (32'(cfg.pixel_count) > 32'(FRAME_MAX))
        begin
            pif = POS_W'(FRAME_MAX);
        end
        else
        begin
            pif = POS_W'(cfg.pixel_count);
        end
    end

    // While a pixel read is outstanding the word comes straight from the
    // store, and the first high segment length is settled from its top bit.
    always_comb
    begin
        cur_word  = pend_reg ? rd_word : word_reg;
        sh        = SH_W'(BITS_PER_PIXEL - 1) - SH_W'(bitpos_reg);
        sh_n      = sh - 1'b1;
        cur_bit   = (sh < SH_W'(COLOR_W)) ? cur_word[sh[CB_W-1:0]] : 1'b0;
        nxt_bit   = (sh_n < SH_W'(COLOR_W)) ? cur_word[sh_n[CB_W-1:0]] : 1'b0;
        cur_count = pend_reg ? at_least_one({8'h00, cur_bit ? plen1_reg : plen0_reg})
                             : count_reg;
    end

    // Next state
    always_comb
    begin
        active_next = active_reg;
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        bitpos_next = bitpos_reg;
        count_next  = cur_count;
        word_next   = cur_word;
        pend_next   = 1'b0;
        plen0_next  = plen0_reg;
        plen1_next  = plen1_reg;
        start_pixel = 1'b0;
        start_pos   = '0;
        rd_go       = 1'b0;
        set_ok      = 1'b0;
        clear_hit   = 1'b0;
        rej         = 1'b0;

        if (fire)
        begin
            if (kind == KIND_TICK)
            begin
                priority if (phase_reg == PH_IDLE)
                begin
                    count_next = cur_count;
                end
                else if (cur_count > 16'd1)
                begin
                    count_next = cur_count - 16'd1;
                end
                else
                begin
                    unique case (phase_reg)
                        PH_HIGH:
                        begin
                            phase_next = PH_LOW;
                            count_next = at_least_one({8'h00,
                                cur_bit ? cfg.one_low : cfg.zero_low});
                        end
                        PH_LOW:
                        begin
                            if (bitpos_reg == BP_W'(BITS_PER_PIXEL - 1))
                            begin
                                pos_next    = pos_reg + 1'b1;
                                start_pixel = 1'b1;
                                start_pos   = pos_reg + 1'b1;
                            end
                            else
                            begin
                                bitpos_next = bitpos_reg + 1'b1;
                                phase_next  = PH_HIGH;
                                count_next  = at_least_one({8'h00,
                                    nxt_bit ? cfg.one_high : cfg.zero_high});
                            end
                        end
                        PH_GAP:
                        begin
                            phase_next  = PH_IDLE;
                            count_next  = '0;
                            active_next = 1'b0;
                            pos_next    = '0;
                            bitpos_next = '0;
                        end
                        PH_IDLE:
                        begin
                            count_next = cur_count;
                        end
                    endcase
                end
            end
            else if (active_reg)
            begin
                rej = 1'b1;
            end
            else
            begin
                unique case (kind)
                    KIND_SET:
                    begin
                        if (32'(pixel_index) < 32'(pif))
                        begin
                            set_ok = 1'b1;
                        end
                        else
                        begin
                            rej = 1'b1;
                        end
                    end
                    KIND_SHOW, KIND_CLEAR:
                    begin
                        clear_hit   = (kind == KIND_CLEAR);
                        active_next = 1'b1;
                        pos_next    = '0;
                        start_pixel = 1'b1;
                        start_pos   = '0;
                    end
                    KIND_TICK:
                    begin
                        rej = 1'b0;
                    end
                endcase
            end
        end

        // Start of a pixel: fetch its word, or go to the latch gap.
        if (start_pixel)
        begin
            bitpos_next = '0;
            if (start_pos >= pif)
            begin
                phase_next = PH_GAP;
                count_next = at_least_one(cfg.reset_gap);
            end
            else
            begin
                phase_next = PH_HIGH;
                pend_next  = 1'b1;
                rd_go      = 1'b1;
                plen0_next = cfg.zero_high;
                plen1_next = cfg.one_high;
            end
        end
    end

    // Outputs
    always_comb
    begin
        st_req.wr_en   = set_ok;
        st_req.rd_en   = rd_go;
        st_req.clear   = clear_hit;
        raddr          = start_pos;
        res.line_level = (phase_next == PH_HIGH);
        res.busy_res   = active_next;
        res.rejected   = rej;
        status.active  = active_reg;
        status.phase   = phase_reg;
        status.pend    = pend_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            phase_reg  <= PH_IDLE;
            pos_reg    <= '0;
            bitpos_reg <= '0;
            count_reg  <= '0;
            word_reg   <= '0;
            pend_reg   <= 1'b0;
            plen0_reg  <= '0;
            plen1_reg  <= '0;
        end
        else
        begin
            active_reg <= active_next;
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            bitpos_reg <= bitpos_next;
            count_reg  <= count_next;
            word_reg   <= word_next;
            pend_reg   <= pend_next;
            plen0_reg  <= plen0_next;
            plen1_reg  <= plen1_next;
        end
    end

endmodule

>>> tb/tb_addressable_led_frame_sender.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_addressable_led_frame_sender
// Drives set, show, clear and tick commands into the LED frame sender, keeps
// its own model of the pixel store and the one-wire waveform, and checks
// every result transfer against the predicted line level, busy flag and
// rejection flag.
// ---------------------------------------------------------------------------
module tb_addressable_led_frame_sender;
    import alfs_pkg::*;

    localparam int LED_LIMIT = 256;
    localparam int ITEM_TARGET = 1850;

    typedef struct packed {
        cfg_idx_t    idx;
        logic [15:0] data;
    } reg_write_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata = '0;   // [7:0] pixel_index, [31:8] color
    logic [1:0]            s_tuser = '0;   // [1:0] kind
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            m_tdata;        // [0] line_level, [1] busy_res, [2] rejected
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Model of the sender
    logic [23:0]  led_mem [LED_LIMIT];
    logic [7:0]   zero_hi_len, zero_lo_len, one_hi_len, one_lo_len;
    logic [15:0]  latch_len;
    logic [8:0]   led_count;
    logic         frame_on;
    phase_t       wave_now;
    int unsigned  led_pos, bit_idx, ticks_left;
    logic [23:0]  shift_word;

    res_t         expected_results[$];
    reg_write_t   reg_writes[$];
    int unsigned  items_sent = 0;
    int           errors = 0;
    int           stall_left = 0;
    bit           gaps_on = 1'b0;

    addressable_led_frame_sender uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("addressable_led_frame_sender: mismatch");
        $finish;
    end

    // ---------------- model ----------------

    function automatic int unsigned seg_ticks(input logic [15:0] v);
        return (v == 16'd0) ? 1 : int'(v);
    endfunction

    function automatic int unsigned leds_in_frame();
        return (led_count > LED_LIMIT) ? LED_LIMIT : int'(led_count);
    endfunction

    function automatic logic bit_now();
        return shift_word[COLOR_W - 1 - bit_idx];
    endfunction

    function automatic void start_bit();
        wave_now = PH_HIGH;
        ticks_left = seg_ticks(bit_now() ? 16'(one_hi_len) : 16'(zero_hi_len));
    endfunction

    function automatic void start_led_or_latch();
        bit_idx = 0;
        if (led_pos >= leds_in_frame())
        begin
            wave_now = PH_GAP;
            ticks_left = seg_ticks(latch_len);
        end
        else
        begin
            shift_word = led_mem[led_pos];
            start_bit();
        end
    endfunction

    function automatic void wave_step();
        if (wave_now == PH_IDLE)
            return;
        if (ticks_left > 1)
        begin
            ticks_left--;
            return;
        end
        case (wave_now)
            PH_HIGH:
            begin
                wave_now = PH_LOW;
                ticks_left = seg_ticks(bit_now() ? 16'(one_lo_len) : 16'(zero_lo_len));
            end
            PH_LOW:
            begin
                bit_idx++;
                if (bit_idx >= COLOR_W)
                begin
                    led_pos++;
                    start_led_or_latch();
                end
                else
                    start_bit();
            end
            default:
            begin
                wave_now = PH_IDLE;
                ticks_left = 0;
                frame_on = 1'b0;
                led_pos = 0;
                bit_idx = 0;
            end
        endcase
    endfunction

    function automatic res_t led_line_result(input kind_t k, input logic [7:0] idx,
                                             input logic [23:0] color);
        res_t r;
        r.rejected = 1'b0;
        if (k == KIND_TICK)
            wave_step();
        else if (frame_on)
            r.rejected = 1'b1;
        else if (k == KIND_SET)
        begin
            if (idx < leds_in_frame())
                led_mem[idx] = color;
            else
                r.rejected = 1'b1;
        end
        else
        begin
            if (k == KIND_CLEAR)
                for (int i = 0; i < LED_LIMIT; i++)
                    led_mem[i] = '0;
            frame_on = 1'b1;
            led_pos = 0;
            start_led_or_latch();
        end
        r.line_level = (wave_now == PH_HIGH);
        r.busy_res = frame_on;
        return r;
    endfunction

    // ---------------- result checking ----------------

    function automatic void check_field(input string field, input logic want, input logic got);
        if (got !== want)
        begin
            errors++;
            if (errors <= 30)
                $display("%0t: %s expected %0b, got %0b", $time, field, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                errors++;
                if (errors <= 30)
                    $display("%0t: result with none expected, expected nothing, got %h",
                             $time, m_tdata);
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("line_level", want.line_level, m_tdata[0]);
                check_field("busy_res", want.busy_res, m_tdata[1]);
                check_field("rejected", want.rejected, m_tdata[2]);
            end
        end
        // Receiver stalls start at random, only while gaps are on.
        if (stall_left != 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 5);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // ---------------- drivers ----------------

    task automatic send_item(input kind_t k, input logic [7:0] idx, input logic [23:0] color);
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= k;
        s_tdata <= {color, idx};
        do @(posedge clk); while (!s_tready);
        expected_results.push_back(led_line_result(k, idx, color));
        items_sent++;
    endtask

    task automatic send_tick();
        send_item(KIND_TICK, 8'($urandom), 24'($urandom));
    endtask

    task automatic finish_frame();
        while (frame_on)
            send_tick();
    endtask

    // Always waits on a clock edge before it returns, so valid is never driven twice in a step.
    task automatic wait_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (expected_results.size() != 0);
    endtask

    task automatic queue_write(input cfg_idx_t idx, input logic [15:0] data);
        reg_write_t w;
        w.idx = idx;
        w.data = data;
        reg_writes.push_back(w);
    endtask

    task automatic flush_writes();
        reg_write_t w;
        while (reg_writes.size() != 0)
        begin
            w = reg_writes.pop_front();
            cfg_valid <= 1'b1;
            cfg_index <= w.idx;
            cfg_data <= w.data;
            do @(posedge clk); while (!cfg_ready);
            case (w.idx)
                CFG_ZERO_HIGH: zero_hi_len = w.data[7:0];
                CFG_ZERO_LOW:  zero_lo_len = w.data[7:0];
                CFG_ONE_HIGH:  one_hi_len = w.data[7:0];
                CFG_ONE_LOW:   one_lo_len = w.data[7:0];
                CFG_RESET_GAP: latch_len = w.data;
                CFG_PIXEL_CNT: led_count = w.data[8:0];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic set_timing(input logic [7:0] zh, input logic [7:0] zl, input logic [7:0] oh,
                              input logic [7:0] ol, input logic [15:0] gap,
                              input logic [15:0] count);
        wait_results();
        queue_write(CFG_ZERO_HIGH, 16'(zh));
        queue_write(CFG_ZERO_LOW, 16'(zl));
        queue_write(CFG_ONE_HIGH, 16'(oh));
        queue_write(CFG_ONE_LOW, 16'(ol));
        queue_write(CFG_RESET_GAP, gap);
        queue_write(CFG_PIXEL_CNT, count);
        flush_writes();
    endtask

    // ---------------- tests ----------------

    // Reset values: a frame starts over 256 LEDs and every command is refused
    // while busy; the chain is then cut to one LED to keep the frame short.
    task automatic test_default_frame();
        gaps_on = 1'b1;
        send_tick();
        send_item(KIND_SET, 8'd0, 24'hFFFFFF);
        send_item(KIND_SET, 8'd255, 24'h800000);
        send_item(KIND_SHOW, 8'd0, 24'd0);
        send_item(KIND_SET, 8'd1, 24'h123456);
        send_item(KIND_SHOW, 8'd255, 24'hFFFFFF);
        send_item(KIND_CLEAR, 8'd0, 24'd0);
        gaps_on = 1'b0;
        repeat (10)
            send_tick();
        wait_results();
        queue_write(CFG_PIXEL_CNT, 16'd1);
        queue_write(CFG_RESET_GAP, 16'd3);
        flush_writes();
        finish_frame();
        send_tick();
    endtask

    // Longest high segment, and zero lengths standing for one tick.
    task automatic test_long_segments();
        gaps_on = 1'b0;
        set_timing(8'd0, 8'd1, 8'd255, 8'd0, 16'd20, 16'd1);
        send_item(KIND_SET, 8'd0, 24'h800000);
        send_item(KIND_SHOW, 8'd0, 24'd0);
        finish_frame();
    endtask

    // With no LEDs a frame is only the latch gap and every set is refused.
    task automatic test_no_leds();
        gaps_on = 1'b1;
        set_timing(8'd2, 8'd1, 8'd1, 8'd2, 16'd0, 16'd0);
        send_item(KIND_SET, 8'd0, 24'hA5A5A5);
        send_item(KIND_SET, 8'd255, 24'h5A5A5A);
        send_item(KIND_SHOW, 8'd0, 24'd0);
        finish_frame();
        send_tick();
    endtask

    // A count beyond the store size is limited to the store size; the frame
    // is then cut to two LEDs.
    task automatic test_saturated_count();
        gaps_on = 1'b0;
        set_timing(8'd0, 8'd0, 8'd0, 8'd0, 16'd1, 16'h01FF);
        send_item(KIND_SET, 8'd255, 24'hFFFFFF);
        send_item(KIND_SET, 8'd128, 24'h5A5AA5);
        send_item(KIND_SHOW, 8'd0, 24'd0);
        repeat (20)
            send_tick();
        wait_results();
        queue_write(CFG_PIXEL_CNT, 16'd2);
        flush_writes();
        finish_frame();
    endtask

    task automatic test_clear_frame();
        gaps_on = 1'b1;
        set_timing(8'd1, 8'd2, 8'd2, 8'd1, 16'd5, 16'd2);
        send_item(KIND_SET, 8'd0, 24'hFF00FF);
        send_item(KIND_SET, 8'd1, 24'h00FF00);
        send_item(KIND_SET, 8'd2, 24'hC3C3C3);
        send_item(KIND_CLEAR, 8'd0, 24'd0);
        send_item(KIND_CLEAR, 8'd1, 24'hFFFFFF);
        finish_frame();
        send_item(KIND_SHOW, 8'd0, 24'd0);
        finish_frame();
    endtask

    // Registers rewritten part-way through a frame: lengths apply from the
    // next segment, the LED count takes effect at once.
    task automatic test_reconfig_in_frame();
        gaps_on = 1'b1;
        set_timing(8'd1, 8'd1, 8'd2, 8'd2, 16'd4, 16'd4);
        for (int i = 0; i < 4; i++)
            send_item(KIND_SET, 8'(i), 24'($urandom));
        send_item(KIND_SHOW, 8'd0, 24'd0);
        while (led_pos == 0 && bit_idx < 5)
            send_tick();
        wait_results();
        queue_write(CFG_PIXEL_CNT, 16'd1);
        queue_write(CFG_ONE_HIGH, 16'd3);
        queue_write(CFG_ZERO_LOW, 16'd4);
        queue_write(CFG_SPARE_7, 16'($urandom));
        flush_writes();
        finish_frame();

        set_timing(8'd1, 8'd1, 8'd1, 8'd1, 16'd2, 16'd4);
        send_item(KIND_SHOW, 8'd0, 24'd0);
        while (led_pos < 2)
            send_tick();
        wait_results();
        queue_write(CFG_PIXEL_CNT, 16'd1);
        queue_write(CFG_RESET_GAP, 16'd6);
        flush_writes();
        finish_frame();
    endtask

    // Mostly complete set and show/clear sequences on short chains, with stray and
    // refused commands mixed in, until the whole run reaches its item count.
    task automatic test_random_frames();
        int unsigned stop_at;
        int unsigned pick;
        bit          first_pass;
        stop_at = ITEM_TARGET;
        first_pass = 1'b1;
        while (items_sent < stop_at)
        begin
            gaps_on = (stop_at - items_sent > 350) && ($urandom_range(0, 4) != 0);
            if (first_pass || $urandom_range(0, 2) == 0)
            begin
                pick = $urandom_range(0, 9);
                set_timing(8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                           8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                           16'($urandom_range(0, 12)),
                           16'((pick == 0) ? 0 : (pick < 7) ? 1 : (pick < 9) ? 2 : 3));
                first_pass = 1'b0;
            end
            repeat ($urandom_range(0, 4))
            begin
                if ($urandom_range(0, 3) == 0)
                    send_item(KIND_SET, 8'($urandom), 24'($urandom));
                else
                    send_item(KIND_SET, 8'($urandom_range(0, leds_in_frame())),
                              24'($urandom));
            end
            if ($urandom_range(0, 9) == 0)
                send_item(kind_t'($urandom_range(0, 3)), 8'($urandom), 24'($urandom));
            if (!frame_on)
                send_item(($urandom_range(0, 2) == 0) ? KIND_CLEAR : KIND_SHOW,
                          8'($urandom), 24'($urandom));
            while (frame_on)
            begin
                if ($urandom_range(0, 24) == 0)
                    send_item(kind_t'($urandom_range(0, 2)), 8'($urandom), 24'($urandom));
                else
                    send_tick();
            end
            repeat ($urandom_range(0, 2))
                send_tick();
        end
    endtask

    initial
    begin
        for (int i = 0; i < LED_LIMIT; i++)
            led_mem[i] = '0;
        zero_hi_len = RST_ZERO_HIGH;
        zero_lo_len = RST_ZERO_LOW;
        one_hi_len = RST_ONE_HIGH;
        one_lo_len = RST_ONE_LOW;
        latch_len = RST_RESET_GAP;
        led_count = RST_PIXEL_CNT;
        frame_on = 1'b0;
        wave_now = PH_IDLE;
        led_pos = 0;
        bit_idx = 0;
        ticks_left = 0;
        shift_word = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_default_frame();
        test_long_segments();
        test_no_leds();
        test_saturated_count();
        test_clear_frame();
        test_reconfig_in_frame();
        test_random_frames();

        gaps_on = 1'b0;
        wait_results();
        repeat (8) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("addressable_led_frame_sender: match");
        else
            $display("addressable_led_frame_sender: mismatch");
        $finish;
    end

endmodule
